// File: hdl/landmark_dedup_store_assert.svh
// ---------------------------------------------------------------------------
// landmark_dedup_store assertion macros
// Shared property forms for the landmark store checkers. They expect clk_i
// and rst_ni in the scope of use.
// ---------------------------------------------------------------------------
`ifndef LANDMARK_DEDUP_STORE_ASSERT_SVH
`define LANDMARK_DEDUP_STORE_ASSERT_SVH

// same-cycle implication
`define LDS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/lds_pkg.sv
// ---------------------------------------------------------------------------
// lds_pkg
// Types and constants shared by the landmark store controller and datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lds_pkg;

  localparam int unsigned COORD_W  = 24;
  localparam int unsigned RADIUS_W = 16;
  localparam int unsigned R2_W     = 32;
  localparam int unsigned SQ_W     = 48;
  localparam int unsigned SUM_W    = 50;
  localparam int unsigned SLOT_W   = 8;
  localparam int unsigned COUNT_W  = 9;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd300;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } lds_state_e;

  typedef struct packed {
    logic start;
    logic issue;
    logic flush;
    logic finish;
  } lds_cmd_t;

  typedef struct packed {
    logic hit;
    logic issue_done;
    logic pipe_empty;
  } lds_status_t;

endpackage

// File: hdl/lds_ctrl.sv
// ---------------------------------------------------------------------------
// lds_ctrl
// Sequencer for one request: accept, walk the store, deliver the result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lds_ctrl import lds_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  lds_status_t status_i,
  output lds_cmd_t    cmd_o
);

  lds_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q & ~out_ready_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.issue = 1'b1;
        if (status_i.hit || (status_i.issue_done && status_i.pipe_empty)) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: hdl/lds_datapath.sv
// ---------------------------------------------------------------------------
// lds_datapath
// Point store, distance pipeline, entry count and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lds_datapath import lds_pkg::*; #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lds_cmd_t                   cmd_i,
  output lds_status_t                status_o,
  input  logic                       cfg_we_i,
  input  logic [RADIUS_W-1:0]        cfg_wdata_i,
  input  logic signed [COORD_W-1:0]  pos_x_i,
  input  logic signed [COORD_W-1:0]  pos_y_i,
  input  logic signed [COORD_W-1:0]  pos_z_i,
  output logic                       is_new_o,
  output logic                       dropped_full_o,
  output logic [SLOT_W-1:0]          slot_index_o,
  output logic [COUNT_W-1:0]         stored_count_o
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

  logic [RADIUS_W-1:0] radius_q;
  logic [R2_W-1:0]     r2_q;

  logic [COORD_W-1:0] pt_x_q, pt_y_q, pt_z_q;
  logic [CNT_W-1:0]   addr_q, count_q, count_d;
  logic               match_q;

  logic [3*COORD_W-1:0] mem_q [CAPACITY];
  logic [3*COORD_W-1:0] rd_q;
  logic                 mem_we, mem_re;

  logic               v1_q, v2_q, v3_q, v4_q;
  logic [COORD_W:0]   dx, dy, dz;
  logic [COORD_W:0]   mx, my, mz;
  logic [COORD_W-1:0] ax_q, ay_q, az_q;
  logic [SQ_W-1:0]    sqx_q, sqy_q, sqz_q;
  logic [SUM_W-1:0]   sum_q;

  logic               full, hit, store_new;
  logic [31:0]        slot_ext, count_ext;

  assign full      = (count_q == CNT_FULL);
  assign hit       = v4_q && (sum_q < {{(SUM_W-R2_W){1'b0}}, r2_q});
  assign mem_re    = cmd_i.issue && (addr_q != count_q);
  assign store_new = !match_q && !full;
  assign mem_we    = cmd_i.finish && store_new;
  assign count_d   = count_q + CNT_W'(1);

  assign status_o.hit        = hit;
  assign status_o.issue_done = (addr_q == count_q);
  assign status_o.pipe_empty = !(v1_q || v2_q || v3_q || v4_q);

  // configuration and squared radius
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RESET;
    end else if (cfg_we_i) begin
      radius_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    r2_q <= R2_W'(radius_q) * R2_W'(radius_q);
  end

  // point store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[count_q[IDX_W-1:0]] <= {pt_x_q, pt_y_q, pt_z_q};
    end
    if (mem_re) begin
      rd_q <= mem_q[addr_q[IDX_W-1:0]];
    end
  end

  // control state of the walk
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q  <= '0;
      count_q <= '0;
      match_q <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        addr_q  <= '0;
        match_q <= 1'b0;
      end else begin
        if (mem_re) begin
          addr_q <= addr_q + CNT_W'(1);
        end
        if (hit) begin
          match_q <= 1'b1;
        end
      end
      if (mem_we) begin
        count_q <= count_d;
      end
      v1_q <= mem_re && !cmd_i.flush;
      v2_q <= v1_q && !cmd_i.flush;
      v3_q <= v2_q && !cmd_i.flush;
      v4_q <= v3_q && !cmd_i.flush;
    end
  end

  // distance pipeline
  assign dx = {pt_x_q[COORD_W-1], pt_x_q} - {rd_q[3*COORD_W-1], rd_q[3*COORD_W-1:2*COORD_W]};
  assign dy = {pt_y_q[COORD_W-1], pt_y_q} - {rd_q[2*COORD_W-1], rd_q[2*COORD_W-1:COORD_W]};
  assign dz = {pt_z_q[COORD_W-1], pt_z_q} - {rd_q[COORD_W-1], rd_q[COORD_W-1:0]};
  assign mx = dx[COORD_W] ? (~dx + 1'b1) : dx;
  assign my = dy[COORD_W] ? (~dy + 1'b1) : dy;
  assign mz = dz[COORD_W] ? (~dz + 1'b1) : dz;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      pt_x_q <= pos_x_i;
      pt_y_q <= pos_y_i;
      pt_z_q <= pos_z_i;
    end
    ax_q  <= mx[COORD_W-1:0];
    ay_q  <= my[COORD_W-1:0];
    az_q  <= mz[COORD_W-1:0];
    sqx_q <= SQ_W'(ax_q) * SQ_W'(ax_q);
    sqy_q <= SQ_W'(ay_q) * SQ_W'(ay_q);
    sqz_q <= SQ_W'(az_q) * SQ_W'(az_q);
    sum_q <= {2'b00, sqx_q} + {2'b00, sqy_q} + {2'b00, sqz_q};
  end

  // result register
  assign slot_ext  = store_new ? 32'(count_q) : 32'd0;
  assign count_ext = store_new ? 32'(count_d) : 32'(count_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      is_new_o       <= !match_q;
      dropped_full_o <= !match_q && full;
      slot_index_o   <= slot_ext[SLOT_W-1:0];
      stored_count_o <= count_ext[COUNT_W-1:0];
    end
  end

endmodule

// File: hdl/landmark_dedup_store.sv
// The store sits in one memory with a single read port, so the walk reads one
// entry per cycle through a four-stage squared-distance pipeline; it ends
// early when a stored point matches, else once every held entry has been read
// and the pipeline has drained, and then the decision and the append follow.
// Only one request is in flight; the result waits in an output register, and
// the next request is taken once the walk is over and the result has been
// written to that register. The store needs no clearing after reset, since
// only entries below the count are ever read.
// ---------------------------------------------------------------------------
// landmark_dedup_store
// De-duplicating store of 3D landmark points with a squared-radius match.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module landmark_dedup_store import lds_pkg::*; #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [RADIUS_W-1:0]        cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [COORD_W-1:0]  pos_x_i,
  input  logic signed [COORD_W-1:0]  pos_y_i,
  input  logic signed [COORD_W-1:0]  pos_z_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       is_new_o,
  output logic                       dropped_full_o,
  output logic [SLOT_W-1:0]          slot_index_o,
  output logic [COUNT_W-1:0]         stored_count_o
);

  lds_cmd_t    cmd;
  lds_status_t status;

  lds_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lds_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .pos_z_i        (pos_z_i),
    .is_new_o       (is_new_o),
    .dropped_full_o (dropped_full_o),
    .slot_index_o   (slot_index_o),
    .stored_count_o (stored_count_o)
  );

endmodule

// File: hdl/lds_checker.sv
// ---------------------------------------------------------------------------
// lds_checker
// Port-level checks on the landmark store, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "landmark_dedup_store_assert.svh"

module lds_checker import lds_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               is_new_o,
  input logic               dropped_full_o,
  input logic [SLOT_W-1:0]  slot_index_o,
  input logic [COUNT_W-1:0] stored_count_o
);

  `LDS_ASSERT_NOW(a_drop_is_new, out_valid_o && dropped_full_o, is_new_o, "drop without new point")
  `LDS_ASSERT_NOW(a_known_clean, out_valid_o && !is_new_o, (slot_index_o == 8'd0) && !dropped_full_o, "known point carries slot or drop")
  `LDS_ASSERT_NEXT(a_busy_after_req, in_valid_i && in_ready_o, !in_ready_o, "request taken while busy")
  `LDS_ASSERT_NEXT(a_result_holds, out_valid_o && !out_ready_i, out_valid_o && $stable(stored_count_o) && $stable(is_new_o), "stalled result changed")

endmodule

bind landmark_dedup_store lds_checker u_lds_checker (.*);

// File: tb/sv/landmark_dedup_store_test.sv
// ---------------------------------------------------------------------------
// landmark_dedup_store_test
// Self-checking bench for the landmark de-duplicating store. A short table of
// directed requests covers the coordinate extremes, the radius boundary, zero
// and maximum radius and known points. Random phases follow, each with a new
// match radius, mixing near copies of held points with fresh ones until the
// store saturates. A local model predicts each result not given in the table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module landmark_dedup_store_test;
  import lds_pkg::*;

  localparam int CAPACITY     = 256;
  localparam int DIR_N        = 21;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 125;
  localparam int HOLD_AT      = 60;
  localparam int HOLD_LEN     = 3000;
  localparam int STALL_LIMIT  = 20000;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic               is_new;
    logic               dropped_full;
    logic [SLOT_W-1:0]  slot_index;
    logic [COUNT_W-1:0] stored_count;
  } verdict_t;

  typedef struct packed {
    logic                set_r;
    logic [RADIUS_W-1:0] radius;
    coord_t              x;
    coord_t              y;
    coord_t              z;
    logic                typed;
    verdict_t            want;
  } step_t;

  localparam coord_t   C_MIN = 24'h800000;
  localparam coord_t   C_MAX = 24'h7FFFFF;
  localparam verdict_t NO_V  = '0;

  localparam step_t PLAN [DIR_N] = '{
    '{1'b0, 16'd0,     24'd0,      24'd0,      24'd0,      1'b1, '{1'b1, 1'b0, 8'd0, 9'd1}},
    '{1'b0, 16'd0,     24'd0,      24'd0,      24'd0,      1'b1, '{1'b0, 1'b0, 8'd0, 9'd1}},
    '{1'b0, 16'd0,     24'd299,    24'd0,      24'd0,      1'b1, '{1'b0, 1'b0, 8'd0, 9'd1}},
    '{1'b0, 16'd0,     24'd300,    24'd0,      24'd0,      1'b1, '{1'b1, 1'b0, 8'd1, 9'd2}},
    '{1'b0, 16'd0,     C_MIN,      C_MIN,      C_MIN,      1'b1, '{1'b1, 1'b0, 8'd2, 9'd3}},
    '{1'b0, 16'd0,     C_MAX,      C_MAX,      C_MAX,      1'b1, '{1'b1, 1'b0, 8'd3, 9'd4}},
    '{1'b0, 16'd0,     C_MAX,      C_MIN,      C_MAX,      1'b0, NO_V},
    '{1'b0, 16'd0,     C_MIN,      C_MAX,      C_MIN,      1'b0, NO_V},
    '{1'b0, 16'd0,     24'd100,    24'd100,    24'd100,    1'b0, NO_V},
    '{1'b0, 16'd0,     24'd173,    24'd173,    24'd173,    1'b0, NO_V},
    '{1'b0, 16'd0,     24'd174,    24'd174,    24'd173,    1'b0, NO_V},
    '{1'b0, 16'd0,     24'h555555, 24'hAAAAAA, 24'h0F0F0F, 1'b0, NO_V},
    '{1'b0, 16'd0,     24'hAAAAAA, 24'h555555, 24'hF0F0F0, 1'b0, NO_V},
    '{1'b1, 16'd0,     24'd0,      24'd0,      24'd0,      1'b0, NO_V},
    '{1'b0, 16'd0,     24'd0,      24'd0,      24'd0,      1'b0, NO_V},
    '{1'b1, 16'd65535, 24'd65535,  24'd0,      24'd0,      1'b0, NO_V},
    '{1'b0, 16'd0,     24'hFFFFFF, 24'd0,      24'd0,      1'b0, NO_V},
    '{1'b0, 16'd0,     24'h7F0000, 24'd0,      24'd0,      1'b0, NO_V},
    '{1'b1, 16'd1,     24'd0,      24'd0,      24'd0,      1'b0, NO_V},
    '{1'b0, 16'd0,     24'd1,      24'd0,      24'd0,      1'b0, NO_V},
    '{1'b1, 16'd300,   24'd0,      24'd0,      24'hFFFED5, 1'b0, NO_V}
  };

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [RADIUS_W-1:0] cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  coord_t              pos_x_i     = '0;
  coord_t              pos_y_i     = '0;
  coord_t              pos_z_i     = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                is_new_o;
  logic                dropped_full_o;
  logic [SLOT_W-1:0]   slot_index_o;
  logic [COUNT_W-1:0]  stored_count_o;

  coord_t              held_x [CAPACITY];
  coord_t              held_y [CAPACITY];
  coord_t              held_z [CAPACITY];
  int                  held_count = 0;
  logic [RADIUS_W-1:0] radius_mm  = RADIUS_RESET;

  verdict_t verdicts_due [$];
  int       failures      = 0;
  int       results_seen  = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       hold_left     = 0;
  bit       hold_done     = 1'b0;

  landmark_dedup_store #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .pos_z_i       (pos_z_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .is_new_o      (is_new_o),
    .dropped_full_o(dropped_full_o),
    .slot_index_o  (slot_index_o),
    .stored_count_o(stored_count_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic verdict_t match_and_append(coord_t x, coord_t y, coord_t z);
    verdict_t v;
    longint   r2;
    longint   dx;
    longint   dy;
    longint   dz;
    bit       hit;
    int       i;
    r2  = longint'(radius_mm) * longint'(radius_mm);
    hit = 1'b0;
    for (i = 0; i < held_count && !hit; i++) begin
      dx = longint'(x) - longint'(held_x[i]);
      dy = longint'(y) - longint'(held_y[i]);
      dz = longint'(z) - longint'(held_z[i]);
      if (dx * dx + dy * dy + dz * dz < r2) hit = 1'b1;
    end
    v = '0;
    v.is_new = !hit;
    if (!hit) begin
      if (held_count < CAPACITY) begin
        held_x[held_count] = x;
        held_y[held_count] = y;
        held_z[held_count] = z;
        v.slot_index = SLOT_W'(held_count);
        held_count++;
      end else begin
        v.dropped_full = 1'b1;
      end
    end
    v.stored_count = COUNT_W'(held_count);
    return v;
  endfunction

  function automatic coord_t extreme_coord();
    case ($urandom_range(4))
      0: return C_MIN;
      1: return C_MAX;
      2: return '0;
      3: return '1;
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic log_mismatch(string what, longint got, longint want);
    failures++;
    $display("mismatch: %s got %0d want %0d at %0t", what, got, want, $realtime);
  endtask

  task automatic push_request(coord_t x, coord_t y, coord_t z, bit typed, verdict_t typed_v);
    verdict_t v;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    pos_x_i    <= x;
    pos_y_i    <= y;
    pos_z_i    <= z;
    do @(posedge clk_i); while (!in_ready_o);
    v = match_and_append(x, y, z);
    verdicts_due.insert(verdicts_due.size(), typed ? typed_v : v);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_radius(logic [RADIUS_W-1:0] value);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    radius_mm   = value;
  endtask

  // hold off once for a long stretch so the block backs up its input
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_done   = 1'b1;
      hold_left   = HOLD_LEN;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (verdicts_due.size() == 0) begin
        log_mismatch("result with no request pending", stored_count_o, 0);
      end else begin
        want = verdicts_due.pop_front();
        if (is_new_o !== want.is_new)
          log_mismatch("is_new", is_new_o, want.is_new);
        if (dropped_full_o !== want.dropped_full)
          log_mismatch("dropped_full", dropped_full_o, want.dropped_full);
        if (slot_index_o !== want.slot_index)
          log_mismatch("slot_index", slot_index_o, want.slot_index);
        if (stored_count_o !== want.stored_count)
          log_mismatch("stored_count", stored_count_o, want.stored_count);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    int     i;
    int     ph;
    int     kind;
    int     k;
    int     span;
    int     off;
    coord_t x;
    coord_t y;
    coord_t z;
    send_idle_pct = 10;
    recv_idle_pct = 63;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < DIR_N; i++) begin
      if (PLAN[i].set_r) write_radius(PLAN[i].radius);
      push_request(PLAN[i].x, PLAN[i].y, PLAN[i].z, PLAN[i].typed, PLAN[i].want);
    end

    for (ph = 0; ph < PHASES; ph++) begin
      send_idle_pct = (ph < 2) ? 10 : (ph < 4) ? 63 : 0;
      recv_idle_pct = (ph < 2) ? 63 : (ph < 4) ? 10 : 0;
      case (ph)
        0:       write_radius(RADIUS_W'($urandom_range(2000)));
        1:       write_radius(16'hFFFF);
        2:       write_radius(16'd0);
        3:       write_radius(RADIUS_W'($urandom_range(65535)));
        4:       write_radius(16'd300);
        default: write_radius(RADIUS_W'($urandom_range(1000, 1)));
      endcase
      for (i = 0; i < PHASE_ITEMS; i++) begin
        kind = $urandom_range(99);
        if (held_count == 0 || kind >= 55) begin
          if (kind >= 90) begin
            x = extreme_coord();
            y = extreme_coord();
            z = extreme_coord();
          end else begin
            x = coord_t'($urandom);
            y = coord_t'($urandom);
            z = coord_t'($urandom);
          end
        end else begin
          k    = $urandom_range(held_count - 1);
          x    = held_x[k];
          y    = held_y[k];
          z    = held_z[k];
          span = int'(radius_mm) + 2;
          if (kind < 30) begin
            x = coord_t'(int'(x) + int'($urandom_range(span)) - span / 2);
            y = coord_t'(int'(y) + int'($urandom_range(span)) - span / 2);
            z = coord_t'(int'(z) + int'($urandom_range(span)) - span / 2);
          end else if (kind < 45) begin
            // straddle the radius along one axis
            off = int'(radius_mm) - 1 + int'($urandom_range(2));
            x   = coord_t'(int'(x) + ($urandom_range(1) ? off : -off));
          end
        end
        push_request(x, y, z, 1'b0, NO_V);
      end
    end

    settle();
    repeat (20) @(posedge clk_i);
    if (failures == 0 && verdicts_due.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/lds_pkg.sv
hdl/lds_ctrl.sv
hdl/lds_datapath.sv
hdl/landmark_dedup_store.sv
hdl/lds_checker.sv
tb/sv/landmark_dedup_store_test.sv
